>>> sv/ssd_pkg.sv
package ssd_pkg;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  digit;
    logic [11:0] number;
    logic        dot;
  } req_t;

  typedef struct packed {
    logic [7:0] seg_low;
    logic [7:0] seg_mid;
    logic [7:0] seg_high;
  } rsp_t;

  typedef logic [2:0][7:0] latches_t;

  localparam logic [2:0] KIND_RAW     = 3'd0;
  localparam logic [2:0] KIND_ONE     = 3'd1;
  localparam logic [2:0] KIND_DEC     = 3'd2;
  localparam logic [2:0] KIND_HEX     = 3'd3;
  localparam logic [2:0] KIND_DEC_BLK = 3'd4;
  localparam logic [2:0] KIND_TENTHS  = 3'd5;

  localparam logic [1:0] DIGIT_LOW  = 2'd0;
  localparam logic [1:0] DIGIT_MID  = 2'd1;
  localparam logic [1:0] DIGIT_HIGH = 2'd2;

  localparam logic [9:0]  DEC_MAX      = 10'd999;
  localparam logic [11:0] TENTHS_LIMIT = 12'd1000;
  localparam logic [3:0]  OVER_DIGIT   = 4'd8;

  localparam logic [15:0][7:0] SEG_CODE = {
    8'h71, 8'h79, 8'h5e, 8'h39, 8'h7c, 8'h77, 8'h6f, 8'h7f,
    8'h27, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  function automatic logic [7:0] glyph(input logic [3:0] v, input logic dp);
    logic [7:0] g;
    g = SEG_CODE[v];
    return {dp, g[6:0]};
  endfunction

endpackage

>>> sv/ssd_bcd.sv
module ssd_bcd (
  input  logic [9:0] value,
  output logic [3:0] ones,
  output logic [3:0] tens,
  output logic [3:0] hundreds
);

  // value / 10 and value / 100 by reciprocal multiply, exact below 1000
  logic [17:0] q_prod;
  logic [15:0] h_prod;
  logic [6:0]  q;
  logic [3:0]  h;
  logic [9:0]  q_x10;
  logic [6:0]  h_x10;
  logic [9:0]  ones_w;
  logic [6:0]  tens_w;

  always_comb begin
    q_prod   = 18'(value) * 18'd205;
    h_prod   = 16'(value) * 16'd41;
    q        = q_prod[17:11];
    h        = h_prod[15:12];
    q_x10    = 10'(q) * 10'd10;
    h_x10    = 7'(h) * 7'd10;
    ones_w   = value - q_x10;
    tens_w   = q - h_x10;
    ones     = ones_w[3:0];
    tens     = tens_w[3:0];
    hundreds = h;
  end

endmodule

>>> sv/ssd_update.sv
module ssd_update (
  input  ssd_pkg::req_t     req,
  input  ssd_pkg::latches_t cur,
  output ssd_pkg::latches_t nxt
);

  logic [9:0] dec_value;
  logic [3:0] d_ones;
  logic [3:0] d_tens;
  logic [3:0] d_hund;
  logic       over;
  logic [7:0] one_glyph;

  always_comb begin
    if (req.number > 12'(ssd_pkg::DEC_MAX)) begin
      dec_value = ssd_pkg::DEC_MAX;
    end else begin
      dec_value = req.number[9:0];
    end
  end

  ssd_bcd u_bcd (
    .value    (dec_value),
    .ones     (d_ones),
    .tens     (d_tens),
    .hundreds (d_hund)
  );

  assign over      = req.number >= ssd_pkg::TENTHS_LIMIT;
  assign one_glyph = ssd_pkg::glyph(req.number[3:0], req.dot);

  always_comb begin
    nxt = cur;
    case (req.kind)
      ssd_pkg::KIND_RAW, ssd_pkg::KIND_ONE: begin
        case (req.digit)
          ssd_pkg::DIGIT_LOW: begin
            nxt[0] = (req.kind == ssd_pkg::KIND_RAW) ? req.number[7:0] : one_glyph;
          end
          ssd_pkg::DIGIT_MID: begin
            nxt[1] = (req.kind == ssd_pkg::KIND_RAW) ? req.number[7:0] : one_glyph;
          end
          ssd_pkg::DIGIT_HIGH: begin
            nxt[2] = (req.kind == ssd_pkg::KIND_RAW) ? req.number[7:0] : one_glyph;
          end
          default: begin
          end
        endcase
      end
      ssd_pkg::KIND_DEC: begin
        nxt[0] = ssd_pkg::glyph(d_ones, 1'b0);
        nxt[1] = ssd_pkg::glyph(d_tens, 1'b0);
        nxt[2] = ssd_pkg::glyph(d_hund, 1'b0);
      end
      ssd_pkg::KIND_HEX: begin
        nxt[0] = ssd_pkg::glyph(req.number[3:0], 1'b0);
        nxt[1] = ssd_pkg::glyph(req.number[7:4], 1'b0);
        nxt[2] = ssd_pkg::glyph(req.number[11:8], 1'b0);
      end
      ssd_pkg::KIND_DEC_BLK: begin
        nxt[0] = ssd_pkg::glyph(d_ones, 1'b0);
        if (d_hund != 4'd0) begin
          nxt[1] = ssd_pkg::glyph(d_tens, 1'b0);
          nxt[2] = ssd_pkg::glyph(d_hund, 1'b0);
        end else if (d_tens != 4'd0) begin
          nxt[1] = ssd_pkg::glyph(d_tens, 1'b0);
        end else begin
          nxt[1] = 8'h00;
          nxt[2] = 8'h00;
        end
      end
      ssd_pkg::KIND_TENTHS: begin
        if (over) begin
          nxt[0] = ssd_pkg::glyph(ssd_pkg::OVER_DIGIT, 1'b0);
          nxt[1] = ssd_pkg::glyph(ssd_pkg::OVER_DIGIT, 1'b0);
          nxt[2] = ssd_pkg::glyph(ssd_pkg::OVER_DIGIT, 1'b0);
        end else begin
          nxt[0] = ssd_pkg::glyph(d_ones, 1'b0);
          nxt[1] = ssd_pkg::glyph(d_tens, 1'b1);
          nxt[2] = ssd_pkg::glyph(d_hund, 1'b0);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/seven_segment_number_display_core.sv
// channel | valid    | ready     | payload
// request | in_valid | in_ready  | in_data  (ssd_pkg::req_t)
// result  | out_valid| out_ready | out_data (ssd_pkg::rsp_t)
//
// A request accepted into the input register is decoded, and the latch update is
// written to the latch and result registers once the result is free or taken.
// One request per cycle with out_ready high; BCD reciprocal multiply sets the path.
// Synchronous reset clears valid flags and all three latches (digits dark).
// A stalled result holds the input register; in_ready follows out_ready then.
module seven_segment_number_display_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ssd_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ssd_pkg::rsp_t out_data
);

  logic              req_valid;
  ssd_pkg::req_t     req;
  ssd_pkg::latches_t latches;
  ssd_pkg::latches_t latches_next;
  logic              advance;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  ssd_update u_update (
    .req (req),
    .cur (latches),
    .nxt (latches_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latches <= '0;
    end else if (advance) begin
      latches <= latches_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.seg_low  <= latches_next[0];
      out_data.seg_mid  <= latches_next[1];
      out_data.seg_high <= latches_next[2];
    end
  end

endmodule
